[rtl/acsi_disk_command_target_top_defines.svh]
// Assertion macros shared by the disk command target RTL.
`ifndef ACSI_DISK_COMMAND_TARGET_TOP_DEFINES_SVH
`define ACSI_DISK_COMMAND_TARGET_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, switched off while arst_n is low.
`define ACSI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acsi target: same-cycle check failed");

// Next-cycle implication, sampled on clk, switched off while arst_n is low.
`define ACSI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acsi target: next-cycle check failed");

`endif

[rtl/acsi_tgt_pkg.sv]
// Types and constants shared by the disk command target modules.
package acsi_tgt_pkg;

	// Command frame length and byte counter codes.
	localparam logic [2:0] CMD_LEN    = 3'd6;
	localparam logic [2:0] LAST_BYTE  = 3'd5;
	localparam logic [2:0] IDLE_COUNT = 3'd7;

	// DMA mode low byte that selects a status read.
	localparam logic [7:0] STATUS_READ_MODE = 8'h8a;

	// Sense code stored on an unknown opcode.
	localparam logic [7:0] SENSE_INVALID_OPCODE = 8'h20;

	// Mask applied to the opening byte to strip the target ID.
	localparam logic [7:0] OPEN_BYTE_MASK = 8'h1f;

	// Completion status codes.
	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_ERR = 2'd2;

	// Opcodes of command byte zero.
	localparam logic [7:0] OP_TEST_READY   = 8'h00;
	localparam logic [7:0] OP_REQ_SENSE    = 8'h03;
	localparam logic [7:0] OP_FORMAT       = 8'h04;
	localparam logic [7:0] OP_READ         = 8'h08;
	localparam logic [7:0] OP_WRITE        = 8'h0a;
	localparam logic [7:0] OP_SEEK         = 8'h0b;
	localparam logic [7:0] OP_INQUIRY      = 8'h12;
	localparam logic [7:0] OP_MODE_SELECT  = 8'h15;

	// Register indexes on the configuration port (word address).
	localparam logic [1:0] REG_DEVICE_ID    = 2'd0;
	localparam logic [1:0] REG_DISK_PRESENT = 2'd1;
	localparam logic [1:0] REG_DISK_SECTORS = 2'd2;

	// Action handed on to the DMA engine.
	typedef enum logic [3:0] {
		ACT_READY        = 4'd0,
		ACT_SENSE        = 4'd1,
		ACT_FORMAT       = 4'd2,
		ACT_READ         = 4'd3,
		ACT_WRITE        = 4'd4,
		ACT_SEEK         = 4'd5,
		ACT_INQUIRY      = 4'd6,
		ACT_MODE_SELECT  = 4'd7,
		ACT_INVALID      = 4'd8
	} action_t;

	// Configuration registers as seen by the command core.
	typedef struct packed {
		logic [2:0]  device_id;
		logic        disk_present;
		logic [24:0] disk_sectors;
	} cfg_t;

	// One bus access.
	typedef struct packed {
		logic       command;
		logic       a1_line;
		logic [7:0] data_byte;
		logic [7:0] dma_mode;
	} item_t;

	// One result word; the lower 55 bits match the output tdata layout and
	// command_done on top travels as tlast.
	typedef struct packed {
		logic        command_done;
		logic [7:0]  sense_code;
		logic [1:0]  status_code;
		logic [7:0]  xfer_len;
		logic [23:0] block_address;
		action_t     action;
		logic        irq_asserted;
		logic [7:0]  read_data;
	} result_t;

endpackage

[rtl/acsi_tgt_cfg.sv]
// APB-style register file holding the target configuration.
module acsi_tgt_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output acsi_tgt_pkg::cfg_t   cfg
);

	logic [2:0]  device_id_q;
	logic        disk_present_q;
	logic [24:0] disk_sectors_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes; addresses beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q    <= '0;
			disk_present_q <= 1'b0;
			disk_sectors_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				acsi_tgt_pkg::REG_DEVICE_ID:    device_id_q    <= pwdata[2:0];
				acsi_tgt_pkg::REG_DISK_PRESENT: disk_present_q <= pwdata[0];
				acsi_tgt_pkg::REG_DISK_SECTORS: disk_sectors_q <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (paddr[3:2])
			acsi_tgt_pkg::REG_DEVICE_ID:    prdata = {29'd0, device_id_q};
			acsi_tgt_pkg::REG_DISK_PRESENT: prdata = {31'd0, disk_present_q};
			acsi_tgt_pkg::REG_DISK_SECTORS: prdata = {7'd0, disk_sectors_q};
			default:                        prdata = '0;
		endcase
	end

	assign cfg.device_id    = device_id_q;
	assign cfg.disk_present = disk_present_q;
	assign cfg.disk_sectors = disk_sectors_q;

endmodule

[rtl/acsi_tgt_core.sv]
// Command collection, opcode decode and status state of the disk target.
`include "acsi_disk_command_target_top_defines.svh"

module acsi_tgt_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  acsi_tgt_pkg::cfg_t      cfg,
	input  logic                    step,
	input  acsi_tgt_pkg::item_t     item,
	output acsi_tgt_pkg::result_t   result
);

	logic [2:0]  cnt_q;
	logic [7:0]  bytes_q [6];
	logic [7:0]  sense_q;
	logic [1:0]  status_q;
	logic        irq_q;

	logic                  is_read;
	logic                  wr;
	logic                  opens;
	logic [2:0]            cnt_eff;
	logic [2:0]            cnt_n;
	logic [7:0]            byte_eff;
	logic                  take;
	logic                  done;
	logic [23:0]           addr;
	logic [7:0]            count;
	logic [24:0]           end_blk;
	acsi_tgt_pkg::action_t act;
	logic                  op_bad;
	logic                  read_bad;
	logic [1:0]            status_n;
	logic [7:0]            sense_n;
	logic                  irq_n;

	// Opening byte detection and the byte counter.
	always_comb begin
		is_read  = item.command;
		wr       = !is_read && cfg.disk_present;
		opens    = wr && !item.a1_line && (item.data_byte[7:5] == cfg.device_id)
			&& (cnt_q == acsi_tgt_pkg::IDLE_COUNT);
		cnt_eff  = opens ? 3'd0 : cnt_q;
		byte_eff = opens ? (item.data_byte & acsi_tgt_pkg::OPEN_BYTE_MASK) : item.data_byte;
		take     = wr && (cnt_eff < acsi_tgt_pkg::CMD_LEN);
		done     = take && (cnt_eff == acsi_tgt_pkg::LAST_BYTE);
		if (done) begin
			cnt_n = acsi_tgt_pkg::IDLE_COUNT;
		end else if (take) begin
			cnt_n = cnt_eff + 3'd1;
		end else begin
			cnt_n = cnt_eff;
		end
	end

	// Opcode decode and the read bound check; the sixth byte is not needed here.
	always_comb begin
		addr    = {bytes_q[1], bytes_q[2], bytes_q[3]};
		count   = bytes_q[4];
		end_blk = {1'b0, addr} + {17'd0, count};
		op_bad  = 1'b0;
		read_bad = 1'b0;
		case (bytes_q[0])
			acsi_tgt_pkg::OP_TEST_READY:  act = acsi_tgt_pkg::ACT_READY;
			acsi_tgt_pkg::OP_REQ_SENSE:   act = acsi_tgt_pkg::ACT_SENSE;
			acsi_tgt_pkg::OP_FORMAT:      act = acsi_tgt_pkg::ACT_FORMAT;
			acsi_tgt_pkg::OP_READ: begin
				act      = acsi_tgt_pkg::ACT_READ;
				read_bad = (count != 8'd0) && (end_blk > cfg.disk_sectors);
			end
			acsi_tgt_pkg::OP_WRITE:       act = acsi_tgt_pkg::ACT_WRITE;
			acsi_tgt_pkg::OP_SEEK:        act = acsi_tgt_pkg::ACT_SEEK;
			acsi_tgt_pkg::OP_INQUIRY:     act = acsi_tgt_pkg::ACT_INQUIRY;
			acsi_tgt_pkg::OP_MODE_SELECT: act = acsi_tgt_pkg::ACT_MODE_SELECT;
			default: begin
				act    = acsi_tgt_pkg::ACT_INVALID;
				op_bad = 1'b1;
			end
		endcase
	end

	// Next status, sense and interrupt level.
	always_comb begin
		status_n = status_q;
		sense_n  = sense_q;
		if (done) begin
			status_n = (op_bad || read_bad) ? acsi_tgt_pkg::STATUS_ERR
				: acsi_tgt_pkg::STATUS_OK;
			if (op_bad) begin
				sense_n = acsi_tgt_pkg::SENSE_INVALID_OPCODE;
			end
		end
		if (is_read) begin
			irq_n = 1'b0;
		end else if (take) begin
			irq_n = 1'b1;
		end else begin
			irq_n = irq_q;
		end
	end

	// Result word for this access.
	always_comb begin
		result.read_data     = (is_read && (item.dma_mode == acsi_tgt_pkg::STATUS_READ_MODE))
			? {6'd0, status_q} : 8'd0;
		result.irq_asserted  = irq_n;
		result.command_done  = done;
		result.action        = done ? act : acsi_tgt_pkg::ACT_READY;
		result.block_address = done ? addr : 24'd0;
		result.xfer_len      = done ? count : 8'd0;
		result.status_code   = status_n;
		result.sense_code    = sense_n;
	end

	// Control state, updated once per processed access.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= acsi_tgt_pkg::IDLE_COUNT;
			sense_q  <= '0;
			status_q <= acsi_tgt_pkg::STATUS_OK;
			irq_q    <= 1'b0;
		end else if (step) begin
			cnt_q    <= cnt_n;
			sense_q  <= sense_n;
			status_q <= status_n;
			irq_q    <= irq_n;
		end
	end

	// Command byte store; entries are only read after they have been written.
	always_ff @(posedge clk) begin
		if (step && take) begin
			bytes_q[cnt_eff] <= byte_eff;
		end
	end

	`ACSI_ASSERT_NOW(a_cnt_never_full, 1'b1, cnt_q != acsi_tgt_pkg::CMD_LEN)
	`ACSI_ASSERT_NEXT(a_done_goes_idle, step && done, cnt_q == acsi_tgt_pkg::IDLE_COUNT)
	`ACSI_ASSERT_NEXT(a_read_clears_irq, step && is_read, !irq_q)
	`ACSI_ASSERT_NOW(a_status_legal, 1'b1,
		(status_q == acsi_tgt_pkg::STATUS_OK) || (status_q == acsi_tgt_pkg::STATUS_ERR))
	`ACSI_ASSERT_NEXT(a_open_takes_byte, step && opens, cnt_q == 3'd1)

endmodule

[rtl/acsi_disk_command_target_top.sv]
// Top level of the disk command target: input stage, result stage and config port.
//
// Usage: each bus access enters as one word on the s_ channel; s_tuser[0] is
// the command (0 write, 1 read), s_tuser[1] the A1 line, s_tdata holds the
// written byte and the DMA mode byte. Every accepted word gives exactly one
// result word on the m_ channel, in order; m_tlast marks the word that
// completed a six-byte command.
// The word is captured in the input register, decoded against the command
// state and written to the result register, from where m_tvalid shows it.
// Throughput is one word per cycle while the receiver keeps m_tready high; the
// command state is a single set of flip-flops updated as each word moves into
// the result register.
// When the receiver holds m_tready low the result register keeps its word,
// the input register fills, and s_tready then falls until space returns.
// Reset clears both stages, puts the byte counter in the idle state and
// clears status, sense code, IRQ and all configuration registers.
// Configuration (device ID, disk present, disk size) is written over the
// APB-style port at byte addresses 0, 4 and 8, with no stall.
module acsi_disk_command_target_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // data_byte [7:0], dma_mode [15:8]
	input  logic [1:0]  s_tuser,  // command [0], a1_line [1]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // read_data [7:0], irq_asserted [8], action [12:9],
	                              // block_address [36:13], xfer_len [44:37],
	                              // status_code [46:45], sense_code [54:47]
	output logic        m_tlast,  // command_done
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	acsi_tgt_pkg::cfg_t    cfg;
	acsi_tgt_pkg::item_t   item_s1;
	acsi_tgt_pkg::result_t result;
	acsi_tgt_pkg::result_t result_s2;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  out_free;
	logic                  advance;

	// Handshake between the two stages.
	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command   <= s_tuser[0];
			item_s1.a1_line   <= s_tuser[1];
			item_s1.data_byte <= s_tdata[7:0];
			item_s1.dma_mode  <= s_tdata[15:8];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// The top bit of the result word leaves as tlast, the rest is padded to whole bytes.
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, result_s2[54:0]};
	assign m_tlast  = result_s2.command_done;

	acsi_tgt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acsi_tgt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

endmodule

[tb/tb.sv]
// Self-checking testbench for the disk command target: random bus accesses against a predictor.

// Scoreboard: tracks the target's command state and holds the result words still to come.
class command_scoreboard;
	logic [2:0]  device_id;
	logic        disk_present;
	logic [24:0] disk_sectors;
	logic [2:0]  byte_count;
	logic [7:0]  frame [0:5];
	logic [7:0]  sense;
	logic [1:0]  status;
	logic        irq;
	acsi_tgt_pkg::result_t expected_results [$];
	int          errors;

	function new();
		device_id    = '0;
		disk_present = 1'b0;
		disk_sectors = '0;
		byte_count   = acsi_tgt_pkg::IDLE_COUNT;
		sense        = '0;
		status       = acsi_tgt_pkg::STATUS_OK;
		irq          = 1'b0;
		errors       = 0;
	endfunction

	// Mirror of a configuration register write.
	function void set_reg(logic [1:0] index, logic [31:0] value);
		case (index)
			acsi_tgt_pkg::REG_DEVICE_ID:    device_id    = value[2:0];
			acsi_tgt_pkg::REG_DISK_PRESENT: disk_present = value[0];
			acsi_tgt_pkg::REG_DISK_SECTORS: disk_sectors = value[24:0];
			default: ;
		endcase
	endfunction

	// Works out the result word caused by one accepted bus access.
	function void note_access(logic is_read, logic a1, logic [7:0] wbyte, logic [7:0] mode);
		acsi_tgt_pkg::result_t r;
		logic [7:0]  b;
		logic        took;
		logic [25:0] span;
		r    = '0;
		b    = wbyte;
		took = 1'b0;
		if (is_read) begin
			if (mode == acsi_tgt_pkg::STATUS_READ_MODE)
				r.read_data = {6'd0, status};
			irq = 1'b0;
		end else if (disk_present) begin
			// An opening byte while idle restarts the frame with the ID bits stripped.
			if (!a1 && b[7:5] == device_id && byte_count == acsi_tgt_pkg::IDLE_COUNT) begin
				byte_count = '0;
				b = b & acsi_tgt_pkg::OPEN_BYTE_MASK;
			end
			if (byte_count < acsi_tgt_pkg::CMD_LEN) begin
				frame[byte_count] = b;
				byte_count++;
				took = 1'b1;
			end
			// The sixth byte completes the command and sets the status.
			if (byte_count == acsi_tgt_pkg::CMD_LEN) begin
				r.block_address = {frame[1], frame[2], frame[3]};
				r.xfer_len      = frame[4];
				status          = acsi_tgt_pkg::STATUS_OK;
				case (frame[0])
					acsi_tgt_pkg::OP_TEST_READY:  r.action = acsi_tgt_pkg::ACT_READY;
					acsi_tgt_pkg::OP_REQ_SENSE:   r.action = acsi_tgt_pkg::ACT_SENSE;
					acsi_tgt_pkg::OP_FORMAT:      r.action = acsi_tgt_pkg::ACT_FORMAT;
					acsi_tgt_pkg::OP_READ: begin
						r.action = acsi_tgt_pkg::ACT_READ;
						span = 26'(r.block_address) + 26'(r.xfer_len);
						if (r.xfer_len != 8'd0 && span > 26'(disk_sectors))
							status = acsi_tgt_pkg::STATUS_ERR;
					end
					acsi_tgt_pkg::OP_WRITE:       r.action = acsi_tgt_pkg::ACT_WRITE;
					acsi_tgt_pkg::OP_SEEK:        r.action = acsi_tgt_pkg::ACT_SEEK;
					acsi_tgt_pkg::OP_INQUIRY:     r.action = acsi_tgt_pkg::ACT_INQUIRY;
					acsi_tgt_pkg::OP_MODE_SELECT: r.action = acsi_tgt_pkg::ACT_MODE_SELECT;
					default: begin
						r.action = acsi_tgt_pkg::ACT_INVALID;
						status   = acsi_tgt_pkg::STATUS_ERR;
						sense    = acsi_tgt_pkg::SENSE_INVALID_OPCODE;
					end
				endcase
				r.command_done = 1'b1;
				byte_count     = acsi_tgt_pkg::IDLE_COUNT;
			end
			if (took)
				irq = 1'b1;
		end
		r.irq_asserted = irq;
		r.status_code  = status;
		r.sense_code   = sense;
		expected_results.push_back(r);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Compares one result word from the block with the oldest prediction.
	function void check_result(logic [55:0] word);
		acsi_tgt_pkg::result_t got;
		acsi_tgt_pkg::result_t want;
		got = acsi_tgt_pkg::result_t'(word);
		if (expected_results.size() == 0) begin
			errors++;
			$display("%0t: result word with none expected, expected nothing, actual %h",
				$time, word);
			return;
		end
		want = expected_results.pop_front();
		compare_field("read_data", want.read_data, got.read_data);
		compare_field("irq_asserted", want.irq_asserted, got.irq_asserted);
		compare_field("command_done", want.command_done, got.command_done);
		compare_field("action", want.action, got.action);
		compare_field("block_address", want.block_address, got.block_address);
		compare_field("xfer_len", want.xfer_len, got.xfer_len);
		compare_field("status_code", want.status_code, got.status_code);
		compare_field("sense_code", want.sense_code, got.sense_code);
	endfunction
endclass

module tb;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;  // data_byte [7:0], dma_mode [15:8]
	logic [1:0]  s_tuser  = '0;  // command [0], a1_line [1]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // read_data [7:0], irq_asserted [8], action [12:9],
	                             // block_address [36:13], xfer_len [44:37],
	                             // status_code [46:45], sense_code [54:47]
	logic        m_tlast;        // command_done
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	command_scoreboard sb = new();
	logic calm = 1'b0;
	int   stall_left = 0;
	int   cycles = 0;
	int   sent = 0;

	acsi_disk_command_target_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Receiver side: random stalls, none while calm.
	always @(posedge clk) begin
		if (calm) begin
			stall_left = 0;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			m_tready <= (stall_left == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watch both handshakes.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready === 1'b1)
			sb.note_access(s_tuser[0], s_tuser[1], s_tdata[7:0], s_tdata[15:8]);
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_result({m_tlast, m_tdata[54:0]});
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Presents one word and waits until the block takes it.
	task automatic send_access(input logic is_read, input logic a1,
		input logic [7:0] wbyte, input logic [7:0] mode);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {mode, wbyte};
		s_tuser  <= {a1, is_read};
		do @(posedge clk); while (s_tready !== 1'b1);
		sent++;
	endtask

	// Stops sending and waits until every result has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(index, value);
	endtask

	task automatic set_target(input logic [2:0] id, input logic present,
		input logic [24:0] sectors);
		drain();
		write_reg(acsi_tgt_pkg::REG_DEVICE_ID, 32'(id));
		write_reg(acsi_tgt_pkg::REG_DISK_PRESENT, 32'(present));
		write_reg(acsi_tgt_pkg::REG_DISK_SECTORS, 32'(sectors));
	endtask

	// Sends a six-byte command, first byte with A1 low, the rest with any A1.
	task automatic send_frame(input logic [7:0] op, input logic [23:0] addr,
		input logic [7:0] count);
		send_access(1'b0, 1'b0, {sb.device_id, op[4:0]}, 8'h00);
		send_access(1'b0, 1'b1, addr[23:16], 8'hff);
		send_access(1'b0, 1'b1, addr[15:8], 8'h00);
		send_access(1'b0, 1'b1, addr[7:0], 8'hff);
		send_access(1'b0, 1'b0, count, 8'h00);
		send_access(1'b0, 1'b1, 8'hff, 8'hff);
	endtask

	// A well-formed command with random content, sometimes cut short or with reads mixed in.
	task automatic random_command();
		logic [7:0] op;
		logic [7:0] frame_bytes [0:5];
		int         addr;
		int         len;
		case ($urandom_range(0, 9))
			0: op = acsi_tgt_pkg::OP_TEST_READY;
			1: op = acsi_tgt_pkg::OP_REQ_SENSE;
			2: op = acsi_tgt_pkg::OP_FORMAT;
			3, 8: op = acsi_tgt_pkg::OP_READ;
			4: op = acsi_tgt_pkg::OP_WRITE;
			5: op = acsi_tgt_pkg::OP_SEEK;
			6: op = acsi_tgt_pkg::OP_INQUIRY;
			7: op = acsi_tgt_pkg::OP_MODE_SELECT;
			default: op = 8'($urandom_range(0, 31));
		endcase
		// Addresses near the end of the disk exercise the bound check.
		if ($urandom_range(0, 1) == 0) begin
			addr = $urandom_range(0, 24'hffffff);
		end else begin
			addr = int'(sb.disk_sectors) - $urandom_range(0, 300);
			if (addr < 0)
				addr = $urandom_range(0, 300);
			if (addr > 24'hffffff)
				addr = 24'hffffff;
		end
		frame_bytes[0] = {sb.device_id, op[4:0]};
		frame_bytes[1] = addr[23:16];
		frame_bytes[2] = addr[15:8];
		frame_bytes[3] = addr[7:0];
		frame_bytes[4] = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
		frame_bytes[5] = 8'($urandom_range(0, 255));
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 6;
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 9) == 0)
				send_access(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			send_access(1'b0, (i == 0) ? 1'b0 : 1'($urandom_range(0, 1)), frame_bytes[i],
				8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 1) == 0)
			send_access(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				acsi_tgt_pkg::STATUS_READ_MODE);
	endtask

	// A stray read or write.
	task automatic random_noise();
		if ($urandom_range(0, 1) == 0)
			send_access(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				($urandom_range(0, 1) == 0) ? acsi_tgt_pkg::STATUS_READ_MODE
					: 8'($urandom_range(0, 255)));
		else
			send_access(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
	endtask

	task automatic run_phase(input int words);
		int start;
		start = sent;
		while (sent - start < words) begin
			if ($urandom_range(0, 19) == 0)
				calm = ~calm;
			if ($urandom_range(0, 3) != 0)
				random_command();
			else
				random_noise();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No disk yet: a write is ignored, a read still answers.
		send_access(1'b0, 1'b0, acsi_tgt_pkg::OP_READ, 8'h00);
		send_access(1'b1, 1'b0, 8'h00, acsi_tgt_pkg::STATUS_READ_MODE);
		set_target(3'd3, 1'b1, 25'd100);
		// Read running past the disk end, then the status read shows the error.
		send_frame(acsi_tgt_pkg::OP_READ, 24'd96, 8'd5);
		send_access(1'b1, 1'b1, 8'hff, acsi_tgt_pkg::STATUS_READ_MODE);
		// Unknown opcode stores the invalid-opcode sense code.
		send_frame(acsi_tgt_pkg::OPEN_BYTE_MASK, 24'hffffff, 8'hff);
		send_access(1'b1, 1'b0, 8'h00, 8'h00);
		// Wrong ID, and the right ID with A1 high: both ignored while idle.
		send_access(1'b0, 1'b0, 8'he8, 8'hff);
		send_access(1'b0, 1'b1, {3'd3, 5'(acsi_tgt_pkg::OP_READ)}, 8'h00);
		// Zero-count read at the top address is never an error.
		send_frame(acsi_tgt_pkg::OP_READ, 24'hffffff, 8'd0);
		send_access(1'b1, 1'b0, 8'h00, acsi_tgt_pkg::STATUS_READ_MODE);

		// Random phases over several configurations, the extremes among them.
		set_target(3'd5, 1'b1, 25'd1000);
		run_phase(180);
		set_target(3'd0, 1'b1, 25'd0);
		run_phase(180);
		set_target(3'd7, 1'b1, 25'h1000000);
		run_phase(180);
		set_target(3'd3, 1'b1, 25'($urandom_range(0, 25'h1000000)));
		run_phase(180);
		set_target(3'd2, 1'b0, 25'd500);
		run_phase(60);
		set_target(3'($urandom_range(0, 7)), 1'b1, 25'($urandom_range(0, 4096)));
		run_phase(240);
		set_target(3'd1, 1'b1, 25'd1);
		run_phase(180);

		drain();
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
